// ===== hdl/cpp_pkg.sv =====
package cpp_pkg;

	localparam int SCALE_WIDTH = 32;
	localparam int SCALE_FRAC = 16;

	localparam logic [2:0] REG_CAM_X = 3'd0;
	localparam logic [2:0] REG_CAM_Y = 3'd1;
	localparam logic [2:0] REG_CAM_Z = 3'd2;
	localparam logic [2:0] REG_RIGHT = 3'd3;
	localparam logic [2:0] REG_UP = 3'd4;
	localparam logic [2:0] REG_VIEW = 3'd5;
	localparam logic [2:0] REG_SCALE = 3'd6;

	typedef struct packed {
		logic valid;
		logic neg;
		logic degen;
	} div_ctl_t;

endpackage

// ===== hdl/cpp_div_cell.sv =====
module cpp_div_cell #(
	parameter int NUM_WIDTH = 64,
	parameter int QW = 34
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cpp_pkg::div_ctl_t    ctl_in,
	input  logic [NUM_WIDTH-1:0] num_in,
	input  logic [NUM_WIDTH-1:0] den_in,
	input  logic [NUM_WIDTH-1:0] rem_in,
	input  logic [QW-1:0]        quo_in,
	input  logic                 big_in,
	output cpp_pkg::div_ctl_t    ctl_out,
	output logic [NUM_WIDTH-1:0] num_out,
	output logic [NUM_WIDTH-1:0] den_out,
	output logic [NUM_WIDTH-1:0] rem_out,
	output logic [QW-1:0]        quo_out,
	output logic                 big_out
);
	import cpp_pkg::*;

	logic [NUM_WIDTH:0] trial;
	logic [NUM_WIDTH:0] shifted;
	logic               take;

	always_comb begin
		shifted = {rem_in, num_in[NUM_WIDTH-1]};
		trial = shifted - {1'b0, den_in};
		take = !trial[NUM_WIDTH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		num_out <= {num_in[NUM_WIDTH-2:0], 1'b0};
		den_out <= den_in;
		rem_out <= take ? trial[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
		quo_out <= {quo_in[QW-2:0], take};
		big_out <= big_in | quo_in[QW-1];
	end

endmodule

// ===== hdl/cpp_div_chain.sv =====
module cpp_div_chain #(
	parameter int NUM_WIDTH = 64,
	parameter int QW = 34
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cpp_pkg::div_ctl_t    ctl_in,
	input  logic [NUM_WIDTH-1:0] num_in,
	input  logic [NUM_WIDTH-1:0] den_in,
	output cpp_pkg::div_ctl_t    ctl_out,
	output logic [QW-1:0]        quo_out,
	output logic                 big_out
);
	import cpp_pkg::*;

	div_ctl_t             ctl_c [NUM_WIDTH+1];
	logic [NUM_WIDTH-1:0] num_c [NUM_WIDTH+1];
	logic [NUM_WIDTH-1:0] den_c [NUM_WIDTH+1];
	logic [NUM_WIDTH-1:0] rem_c [NUM_WIDTH+1];
	logic [QW-1:0]        quo_c [NUM_WIDTH+1];
	logic                 big_c [NUM_WIDTH+1];

	assign ctl_c[0] = ctl_in;
	assign num_c[0] = num_in;
	assign den_c[0] = den_in;
	assign rem_c[0] = '0;
	assign quo_c[0] = '0;
	assign big_c[0] = 1'b0;

	for (genvar g = 0; g < NUM_WIDTH; g++) begin : g_cell
		cpp_div_cell #(.NUM_WIDTH(NUM_WIDTH), .QW(QW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_in(ctl_c[g]), .num_in(num_c[g]), .den_in(den_c[g]),
			.rem_in(rem_c[g]), .quo_in(quo_c[g]), .big_in(big_c[g]),
			.ctl_out(ctl_c[g+1]), .num_out(num_c[g+1]), .den_out(den_c[g+1]),
			.rem_out(rem_c[g+1]), .quo_out(quo_c[g+1]), .big_out(big_c[g+1])
		);
	end

	assign ctl_out = ctl_c[NUM_WIDTH];
	assign quo_out = quo_c[NUM_WIDTH];
	assign big_out = big_c[NUM_WIDTH] | quo_c[NUM_WIDTH][QW-1];

endmodule

// ===== hdl/camera_point_projection_top.sv =====
// Channel     Signals                                          Direction
// config      psel penable pwrite paddr pwdata prdata pready   host to block, APB style
// request     start busy point_x point_y point_z               in, taken when start and !busy
// result      done screen_x screen_y depth_term                out, one cycle strobe
//             degenerate saturated
// A new request is taken every cycle; busy is always low.
// Six pipeline stages (ray, products, dot sums, magnitudes, scale partial products and
// alignment) feed a chain of divider cells, one per numerator bit (106 at the default
// widths), and then one output register that drives done.
// Reset clears the valid pipe and the registers to their reset values.
// The receiver cannot stall, so nothing ever holds the pipe.
module camera_point_projection_top #(
	parameter int COORD_WIDTH = 32,
	parameter int AXIS_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [5:0]               paddr,
	input  logic [63:0]              pwdata,
	output logic [63:0]              prdata,
	output logic                     pready,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	output logic                     done,
	output logic signed [COORD_WIDTH-1:0] screen_x,
	output logic signed [COORD_WIDTH-1:0] screen_y,
	output logic signed [COORD_WIDTH-1:0] depth_term,
	output logic                     degenerate,
	output logic                     saturated
);
	import cpp_pkg::*;

	localparam int CF = COORD_WIDTH / 2;
	localparam int AF = AXIS_WIDTH - 2;
	localparam int SW = COORD_WIDTH + 1;
	localparam int CW = 2 * AXIS_WIDTH + 1;
	localparam int PW = SW + CW;
	localparam int DW = PW + 2;
	localparam int NW = 2 * AXIS_WIDTH + CW + 2;
	localparam int EXY = CF - SCALE_FRAC;
	localparam int EZ = 2 * CF - SCALE_FRAC - AF;
	localparam int NUMW = DW + SCALE_WIDTH + 2 + ((EXY > 0) ? EXY : 0)
		+ ((EZ > 0) ? EZ : 0) + 2;
	localparam int QW = COORD_WIDTH + 2;
	localparam int HD = (DW + 1) / 2;
	localparam int HZ = (NW + 1) / 2;
	localparam int PPW = HD + SCALE_WIDTH;
	localparam int PPZ = HZ + SCALE_WIDTH;
	localparam int EXYP = (EXY > 0) ? EXY : 0;
	localparam int DXYP = (EXY < 0) ? -EXY : 0;
	localparam int EZP = (EZ > 0) ? EZ : 0;
	localparam int DZP = (EZ < 0) ? -EZ : 0;

	logic signed [COORD_WIDTH-1:0] cam_q [3];
	logic [3*AXIS_WIDTH-1:0] right_q, up_q, view_q;
	logic [SCALE_WIDTH-1:0]  scale_q;
	logic                    wr;
	logic [2:0]              ridx;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign wr = psel && penable && pwrite;
	assign ridx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= '0;
			cam_q[1] <= '0;
			cam_q[2] <= '0;
			right_q <= {AXIS_WIDTH'(0), -AXIS_WIDTH'(signed'(1) <<< AF), AXIS_WIDTH'(0)};
			up_q <= {AXIS_WIDTH'(0), AXIS_WIDTH'(0), AXIS_WIDTH'(1) << AF};
			view_q <= {AXIS_WIDTH'(1) << AF, AXIS_WIDTH'(0), AXIS_WIDTH'(0)};
			scale_q <= SCALE_WIDTH'(32768);
		end else if (wr) begin
			case (ridx)
				REG_CAM_X: cam_q[0] <= pwdata[COORD_WIDTH-1:0];
				REG_CAM_Y: cam_q[1] <= pwdata[COORD_WIDTH-1:0];
				REG_CAM_Z: cam_q[2] <= pwdata[COORD_WIDTH-1:0];
				REG_RIGHT: right_q <= pwdata[3*AXIS_WIDTH-1:0];
				REG_UP:    up_q <= pwdata[3*AXIS_WIDTH-1:0];
				REG_VIEW:  view_q <= pwdata[3*AXIS_WIDTH-1:0];
				REG_SCALE: scale_q <= pwdata[SCALE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (ridx)
			REG_CAM_X: prdata = 64'(unsigned'(cam_q[0]));
			REG_CAM_Y: prdata = 64'(unsigned'(cam_q[1]));
			REG_CAM_Z: prdata = 64'(unsigned'(cam_q[2]));
			REG_RIGHT: prdata = 64'(right_q);
			REG_UP:    prdata = 64'(up_q);
			REG_VIEW:  prdata = 64'(view_q);
			REG_SCALE: prdata = 64'(scale_q);
			default:   prdata = '0;
		endcase
	end

	// Axis components and the three cross products depend on configuration only.
	logic signed [AXIS_WIDTH-1:0] r [3], h [3], n [3];
	logic signed [CW-1:0] c_q [3], a_q [3], b_q [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r[i] = right_q[(2-i)*AXIS_WIDTH +: AXIS_WIDTH];
			h[i] = up_q[(2-i)*AXIS_WIDTH +: AXIS_WIDTH];
			n[i] = view_q[(2-i)*AXIS_WIDTH +: AXIS_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		c_q[0] <= CW'(r[1]) * CW'(h[2]) - CW'(r[2]) * CW'(h[1]);
		c_q[1] <= CW'(r[2]) * CW'(h[0]) - CW'(r[0]) * CW'(h[2]);
		c_q[2] <= CW'(r[0]) * CW'(h[1]) - CW'(r[1]) * CW'(h[0]);
		a_q[0] <= CW'(n[1]) * CW'(h[2]) - CW'(n[2]) * CW'(h[1]);
		a_q[1] <= CW'(n[2]) * CW'(h[0]) - CW'(n[0]) * CW'(h[2]);
		a_q[2] <= CW'(n[0]) * CW'(h[1]) - CW'(n[1]) * CW'(h[0]);
		b_q[0] <= CW'(r[1]) * CW'(n[2]) - CW'(r[2]) * CW'(n[1]);
		b_q[1] <= CW'(r[2]) * CW'(n[0]) - CW'(r[0]) * CW'(n[2]);
		b_q[2] <= CW'(r[0]) * CW'(n[1]) - CW'(r[1]) * CW'(n[0]);
	end

	// Stage 1: ray.
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [SW-1:0] s_s1 [3];
	always_ff @(posedge clk) begin
		s_s1[0] <= SW'(cam_q[0]) - SW'(point_x);
		s_s1[1] <= SW'(cam_q[1]) - SW'(point_y);
		s_s1[2] <= SW'(cam_q[2]) - SW'(point_z);
	end

	// Stage 2: products.
	logic signed [PW-1:0] pd_s2 [3], pa_s2 [3], pb_s2 [3];
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pd_s2[i] <= PW'(s_s1[i]) * PW'(c_q[i]);
			pa_s2[i] <= PW'(s_s1[i]) * PW'(a_q[i]);
			pb_s2[i] <= PW'(s_s1[i]) * PW'(b_q[i]);
		end
	end

	// Stage 3: dot sums.
	logic signed [DW-1:0] det_s3, da_s3, db_s3;
	logic signed [NW-1:0] dz_s3;
	always_ff @(posedge clk) begin
		det_s3 <= DW'(pd_s2[0]) + DW'(pd_s2[1]) + DW'(pd_s2[2]);
		da_s3 <= DW'(pa_s2[0]) + DW'(pa_s2[1]) + DW'(pa_s2[2]);
		db_s3 <= DW'(pb_s2[0]) + DW'(pb_s2[1]) + DW'(pb_s2[2]);
		dz_s3 <= NW'(n[0]) * NW'(c_q[0]) + NW'(n[1]) * NW'(c_q[1])
			+ NW'(n[2]) * NW'(c_q[2]);
	end

	// Stage 4: magnitudes and signs.
	logic [DW-1:0] mdet_s4, ma_s4, mb_s4;
	logic [NW-1:0] mz_s4;
	logic          nd_s4, na_s4, nb_s4, nz_s4, dg_s4;
	always_ff @(posedge clk) begin
		nd_s4 <= det_s3[DW-1];
		na_s4 <= da_s3[DW-1];
		nb_s4 <= db_s3[DW-1];
		nz_s4 <= dz_s3[NW-1];
		mdet_s4 <= det_s3[DW-1] ? -det_s3 : det_s3;
		ma_s4 <= da_s3[DW-1] ? -da_s3 : da_s3;
		mb_s4 <= db_s3[DW-1] ? -db_s3 : db_s3;
		mz_s4 <= dz_s3[NW-1] ? -dz_s3 : dz_s3;
		dg_s4 <= det_s3 == '0;
	end

	// Stage 5: the scale multiplied into the low and high halves of each numerator.
	logic [PPW-1:0] xl_s5, xh_s5, yl_s5, yh_s5;
	logic [PPZ-1:0] zl_s5, zh_s5;
	logic [DW-1:0]  mdet_s5;
	logic           ngx_s5, ngy_s5, ngz_s5, dg_s5;
	always_ff @(posedge clk) begin
		xl_s5 <= PPW'(ma_s4[HD-1:0]) * PPW'(scale_q);
		xh_s5 <= PPW'(ma_s4[DW-1:HD]) * PPW'(scale_q);
		yl_s5 <= PPW'(mb_s4[HD-1:0]) * PPW'(scale_q);
		yh_s5 <= PPW'(mb_s4[DW-1:HD]) * PPW'(scale_q);
		zl_s5 <= PPZ'(mz_s4[HZ-1:0]) * PPZ'(scale_q);
		zh_s5 <= PPZ'(mz_s4[NW-1:HZ]) * PPZ'(scale_q);
		mdet_s5 <= mdet_s4;
		ngx_s5 <= na_s4 == nd_s4;
		ngy_s5 <= nb_s4 == nd_s4;
		ngz_s5 <= nz_s4 == nd_s4;
		dg_s5 <= dg_s4;
	end

	// Stage 6: combine the halves and align numerator and divisor.
	logic [NUMW-1:0] nx_s6, ny_s6, nz_s6, dxy_s6, dz_s6;
	div_ctl_t        cx_s6, cy_s6, cz_s6;
	always_ff @(posedge clk) begin
		nx_s6 <= ((NUMW'(xh_s5) << HD) + NUMW'(xl_s5)) << EXYP;
		ny_s6 <= ((NUMW'(yh_s5) << HD) + NUMW'(yl_s5)) << EXYP;
		nz_s6 <= ((NUMW'(zh_s5) << HZ) + NUMW'(zl_s5)) << EZP;
		dxy_s6 <= NUMW'(mdet_s5) << DXYP;
		dz_s6 <= NUMW'(mdet_s5) << DZP;
		cx_s6 <= '{valid: v_s5, neg: ngx_s5, degen: dg_s5};
		cy_s6 <= '{valid: v_s5, neg: ngy_s5, degen: dg_s5};
		cz_s6 <= '{valid: v_s5, neg: ngz_s5, degen: dg_s5};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	div_ctl_t     ox, oy, oz;
	logic [QW-1:0] qx, qy, qz;
	logic          bx, by, bz;

	cpp_div_chain #(.NUM_WIDTH(NUMW), .QW(QW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .ctl_in(cx_s6), .num_in(nx_s6), .den_in(dxy_s6),
		.ctl_out(ox), .quo_out(qx), .big_out(bx));
	cpp_div_chain #(.NUM_WIDTH(NUMW), .QW(QW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .ctl_in(cy_s6), .num_in(ny_s6), .den_in(dxy_s6),
		.ctl_out(oy), .quo_out(qy), .big_out(by));
	cpp_div_chain #(.NUM_WIDTH(NUMW), .QW(QW)) u_div_z (
		.clk(clk), .arst_n(arst_n), .ctl_in(cz_s6), .num_in(nz_s6), .den_in(dz_s6),
		.ctl_out(oz), .quo_out(qz), .big_out(bz));

	localparam logic [QW-1:0] LIM = QW'(1) << (COORD_WIDTH - 1);

	function automatic logic [COORD_WIDTH:0] clamp(input logic [QW-1:0] q,
			input logic big, input logic neg);
		logic [QW-1:0] nq;
		nq = -q;
		if (neg) begin
			if (big || q > LIM) begin
				return {1'b1, LIM[COORD_WIDTH-1:0]};
			end
			return {1'b0, nq[COORD_WIDTH-1:0]};
		end
		if (big || q > LIM - 1'b1) begin
			return {1'b1, ~LIM[COORD_WIDTH-1:0]};
		end
		return {1'b0, q[COORD_WIDTH-1:0]};
	endfunction

	logic [COORD_WIDTH:0] rx, ry, rz;
	assign rx = clamp(qx, bx, ox.neg);
	assign ry = clamp(qy, by, oy.neg);
	assign rz = clamp(qz, bz, oz.neg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ox.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ox.degen) begin
			screen_x <= '0;
			screen_y <= '0;
			depth_term <= -(COORD_WIDTH'(1) << CF);
			degenerate <= 1'b1;
			saturated <= 1'b0;
		end else begin
			screen_x <= rx[COORD_WIDTH-1:0];
			screen_y <= ry[COORD_WIDTH-1:0];
			depth_term <= rz[COORD_WIDTH-1:0];
			degenerate <= 1'b0;
			saturated <= rx[COORD_WIDTH] | ry[COORD_WIDTH] | rz[COORD_WIDTH];
		end
	end

endmodule
